FILE: hdl/rc4_pkg.sv
// Shared constants, types and register indexes for the RC4 stream cipher.
`timescale 1ns / 1ps

package rc4_pkg;

    localparam int BYTE_W        = 8;
    localparam int SBOX_DEPTH    = 256;
    localparam int KEY_WORDS     = 4;
    localparam int KEY_WORD_W    = 64;
    localparam int MAX_KEY_BYTES = 32;
    localparam int KEY_IDX_W     = 5;
    localparam int KEY_LEN_W     = 6;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 64;

    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 6'd16;

    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_0 = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_1 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_2 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD_3 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LENGTH = 3'd4;

    typedef logic [BYTE_W-1:0] byte_t;

    // Key byte for the current schedule step and the last key index in use.
    typedef struct packed {
        byte_t                key_byte;
        logic [KEY_IDX_W-1:0] last_idx;
    } key_info_t;

endpackage

FILE: hdl/rc4_if.sv
// Valid/ready channel interfaces for the input and output words.
`timescale 1ns / 1ps

interface rc4_in_if;
    logic                 valid;
    logic                 ready;
    rc4_pkg::byte_t       data_in;
    logic                 first_of_message;

    modport source (output valid, output data_in, output first_of_message, input ready);
    modport sink   (input valid, input data_in, input first_of_message, output ready);
endinterface

interface rc4_out_if;
    logic                 valid;
    logic                 ready;
    rc4_pkg::byte_t       data_out;

    modport source (output valid, output data_out, input ready);
    modport sink   (input valid, input data_out, output ready);
endinterface

FILE: hdl/rc4_ram.sv
// Generic RAM: one write port, two registered read ports, old data on collision.
`timescale 1ns / 1ps

module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

FILE: hdl/rc4_key_regs.sv
// Key register file and key byte selection for the key schedule.
`timescale 1ns / 1ps

module rc4_key_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rc4_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [rc4_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [rc4_pkg::KEY_IDX_W-1:0]       key_idx,
    output rc4_pkg::key_info_t                  key_info
);

    logic [rc4_pkg::KEY_WORD_W-1:0] key_word_reg [rc4_pkg::KEY_WORDS];
    logic [rc4_pkg::KEY_LEN_W-1:0]  key_len_reg;
    logic [rc4_pkg::KEY_LEN_W-1:0]  eff_len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < rc4_pkg::KEY_WORDS; w++)
            begin
                key_word_reg[w] <= '0;
            end
            key_len_reg <= rc4_pkg::KEY_LEN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rc4_pkg::REG_KEY_WORD_0: key_word_reg[0] <= cfg_data;
                rc4_pkg::REG_KEY_WORD_1: key_word_reg[1] <= cfg_data;
                rc4_pkg::REG_KEY_WORD_2: key_word_reg[2] <= cfg_data;
                rc4_pkg::REG_KEY_WORD_3: key_word_reg[3] <= cfg_data;
                rc4_pkg::REG_KEY_LENGTH: key_len_reg <= cfg_data[rc4_pkg::KEY_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the length: zero acts as one, anything above the maximum saturates.
    always_comb
    begin
        eff_len = key_len_reg;
        if (key_len_reg == '0)
        begin
            eff_len = rc4_pkg::KEY_LEN_W'(1);
        end
        else if (key_len_reg > rc4_pkg::KEY_LEN_W'(rc4_pkg::MAX_KEY_BYTES))
        begin
            eff_len = rc4_pkg::KEY_LEN_W'(rc4_pkg::MAX_KEY_BYTES);
        end
    end

    assign key_info.last_idx = rc4_pkg::KEY_IDX_W'(eff_len - rc4_pkg::KEY_LEN_W'(1));
    assign key_info.key_byte = key_word_reg[key_idx[4:3]][{key_idx[2:0], 3'b000} +: 8];

endmodule

FILE: hdl/rc4_core.sv
// Sequencer: key schedule and per-byte read-modify-write of the S-box memory.
`timescale 1ns / 1ps

module rc4_core (
    input  logic                              clk,
    input  logic                              rst_n,
    rc4_in_if.sink                            in_ch,
    rc4_out_if.source                         out_ch,
    input  rc4_pkg::key_info_t                key_info,
    output logic [rc4_pkg::KEY_IDX_W-1:0]     key_idx,
    output logic                              ram_we,
    output rc4_pkg::byte_t                    ram_waddr,
    output rc4_pkg::byte_t                    ram_wdata,
    output rc4_pkg::byte_t                    ram_raddr_a,
    input  rc4_pkg::byte_t                    ram_rdata_a,
    output rc4_pkg::byte_t                    ram_raddr_b,
    input  rc4_pkg::byte_t                    ram_rdata_b
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_INIT = 4'd1;
    localparam logic [3:0] ST_KRD  = 4'd2;
    localparam logic [3:0] ST_KJ   = 4'd3;
    localparam logic [3:0] ST_KW1  = 4'd4;
    localparam logic [3:0] ST_KW2  = 4'd5;
    localparam logic [3:0] ST_P0   = 4'd6;
    localparam logic [3:0] ST_S1   = 4'd7;
    localparam logic [3:0] ST_S2   = 4'd8;
    localparam logic [3:0] ST_S3   = 4'd9;

    logic [3:0]                       state_reg;
    rc4_pkg::byte_t                   i_reg;
    rc4_pkg::byte_t                   j_reg;
    rc4_pkg::byte_t                   n_reg;
    rc4_pkg::byte_t                   kj_reg;
    logic [rc4_pkg::KEY_IDX_W-1:0]    kidx_reg;
    rc4_pkg::byte_t                   sa_reg;
    rc4_pkg::byte_t                   sb_reg;
    rc4_pkg::byte_t                   data_reg;
    logic                             done_reg;
    logic                             fwd_hit_reg;
    rc4_pkg::byte_t                   fwd_val_reg;
    logic                             hit_i_reg;
    logic                             hit_j_reg;
    logic                             out_valid_reg;
    rc4_pkg::byte_t                   out_data_reg;

    logic                             accept;
    logic                             need_sched;
    logic                             out_free;
    rc4_pkg::byte_t                   i_plus;
    rc4_pkg::byte_t                   si;
    rc4_pkg::byte_t                   j_new;
    rc4_pkg::byte_t                   kj_new;
    rc4_pkg::byte_t                   t_addr;
    rc4_pkg::byte_t                   ks;

    assign in_ch.ready     = (state_reg == ST_IDLE) || (state_reg == ST_S3);
    assign accept          = in_ch.valid && in_ch.ready;
    assign need_sched      = in_ch.first_of_message || !done_reg;
    assign out_free        = !out_valid_reg || out_ch.ready;
    assign out_ch.valid    = out_valid_reg;
    assign out_ch.data_out = out_data_reg;
    assign key_idx         = kidx_reg;

    assign i_plus = i_reg + 8'd1;
    assign si     = fwd_hit_reg ? fwd_val_reg : ram_rdata_a;
    assign j_new  = j_reg + si;
    assign kj_new = kj_reg + ram_rdata_a + key_info.key_byte;
    assign t_addr = sa_reg + ram_rdata_b;
    assign ks     = hit_i_reg ? sb_reg : (hit_j_reg ? sa_reg : ram_rdata_a);

    always_comb
    begin
        ram_we      = 1'b0;
        ram_waddr   = n_reg;
        ram_wdata   = n_reg;
        ram_raddr_a = i_plus;
        ram_raddr_b = j_reg;
        case (state_reg)
            ST_INIT:
            begin
                ram_we = 1'b1;
            end
            ST_KRD:
            begin
                ram_raddr_a = n_reg;
            end
            ST_KJ:
            begin
                ram_raddr_b = kj_new;
            end
            ST_KW1:
            begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata_b;
            end
            ST_KW2:
            begin
                ram_we    = 1'b1;
                ram_waddr = kj_reg;
                ram_wdata = sa_reg;
            end
            ST_S1:
            begin
                ram_raddr_b = j_new;
            end
            ST_S2:
            begin
                ram_we      = 1'b1;
                ram_waddr   = i_reg;
                ram_wdata   = ram_rdata_b;
                ram_raddr_a = t_addr;
            end
            ST_S3:
            begin
                ram_we    = 1'b1;
                ram_waddr = j_reg;
                ram_wdata = sa_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            n_reg         <= '0;
            kj_reg        <= '0;
            kidx_reg      <= '0;
            done_reg      <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            hit_i_reg     <= 1'b0;
            hit_j_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE, ST_S3:
                begin
                    if (state_reg == ST_S3)
                    begin
                        out_valid_reg <= 1'b1;
                    end
                    if (accept)
                    begin
                        if (need_sched)
                        begin
                            n_reg     <= '0;
                            state_reg <= ST_INIT;
                        end
                        else
                        begin
                            i_reg       <= i_plus;
                            // The swap's second write lands on this edge.
                            fwd_hit_reg <= (state_reg == ST_S3) && (i_plus == j_reg);
                            state_reg   <= ST_S1;
                        end
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_INIT:
                begin
                    n_reg <= n_reg + 8'd1;
                    if (n_reg == 8'hFF)
                    begin
                        kj_reg    <= '0;
                        kidx_reg  <= '0;
                        state_reg <= ST_KRD;
                    end
                end
                ST_KRD:
                begin
                    state_reg <= ST_KJ;
                end
                ST_KJ:
                begin
                    sa_reg    <= ram_rdata_a;
                    kj_reg    <= kj_new;
                    kidx_reg  <= (kidx_reg == key_info.last_idx) ? '0 :
                                 kidx_reg + rc4_pkg::KEY_IDX_W'(1);
                    state_reg <= ST_KW1;
                end
                ST_KW1:
                begin
                    state_reg <= ST_KW2;
                end
                ST_KW2:
                begin
                    n_reg <= n_reg + 8'd1;
                    if (n_reg == 8'hFF)
                    begin
                        i_reg     <= '0;
                        j_reg     <= '0;
                        done_reg  <= 1'b1;
                        state_reg <= ST_P0;
                    end
                    else
                    begin
                        state_reg <= ST_KRD;
                    end
                end
                ST_P0:
                begin
                    i_reg       <= i_plus;
                    fwd_hit_reg <= 1'b0;
                    state_reg   <= ST_S1;
                end
                ST_S1:
                begin
                    sa_reg    <= si;
                    j_reg     <= j_new;
                    state_reg <= ST_S2;
                end
                ST_S2:
                begin
                    if (out_free)
                    begin
                        sb_reg    <= ram_rdata_b;
                        hit_i_reg <= (t_addr == i_reg);
                        hit_j_reg <= (t_addr == j_reg);
                        state_reg <= ST_S3;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= in_ch.data_in;
        end
        if (state_reg == ST_IDLE || state_reg == ST_S3)
        begin
            fwd_val_reg <= sa_reg;
        end
        if (state_reg == ST_S3)
        begin
            out_data_reg <= data_reg ^ ks;
        end
    end

endmodule

FILE: hdl/rc4_stream_cipher.sv
// Top level of the RC4 stream cipher: key registers, S-box memory, sequencer.
`timescale 1ns / 1ps

// RC4 encrypt/decrypt of a byte stream.
// in_ch carries one word per byte: data_in plus first_of_message. out_ch
// returns one word per input word: data_in XOR the next keystream byte.
// Both channels move a word when valid and ready are high at a clock edge.
// The key sits in five registers written through cfg_we/cfg_index/cfg_data:
// four 64-bit little-endian key words and the key length (1 to 32 bytes).
// Write them only while the block is idle.
// A word marked first_of_message, or the first word after reset, starts the
// key schedule: the identity permutation is loaded, the 256 mixing steps run
// and the index i restarts, all before the byte itself is processed.
// Each data byte then goes from acceptance to a valid output in these steps:
// read S[i], read S[j] and write S[i], read the keystream entry and write S[j].
// Those accesses all use the single S-box memory, and the next word is taken
// during the write of S[j].
// Reset (rst_n low, asynchronous) clears the indices, the output valid flag and
// the schedule flag and restores the key length to 16; S-box contents are kept
// but never read before a schedule fills them.
// When the receiver stalls, the result holds in the output register and the
// next byte waits after reading S[j] until that register frees up.
module rc4_stream_cipher (
    input  logic                              clk,
    input  logic                              rst_n,
    rc4_in_if.sink                            in_ch,
    rc4_out_if.source                         out_ch,
    input  logic                              cfg_we,
    input  logic [rc4_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rc4_pkg::CFG_DATA_W-1:0]    cfg_data
);

    rc4_pkg::key_info_t                key_info;
    logic [rc4_pkg::KEY_IDX_W-1:0]     key_idx;
    logic                              ram_we;
    rc4_pkg::byte_t                    ram_waddr;
    rc4_pkg::byte_t                    ram_wdata;
    rc4_pkg::byte_t                    ram_raddr_a;
    rc4_pkg::byte_t                    ram_rdata_a;
    rc4_pkg::byte_t                    ram_raddr_b;
    rc4_pkg::byte_t                    ram_rdata_b;

    // Key words and length; select the key byte for the current schedule step.
    rc4_key_regs u_key_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .key_idx   (key_idx),
        .key_info  (key_info)
    );

    // S-box: 256 bytes, one write and two reads per cycle, registered reads.
    rc4_ram #(
        .WIDTH (rc4_pkg::BYTE_W),
        .DEPTH (rc4_pkg::SBOX_DEPTH)
    ) u_sbox (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .rdata_a (ram_rdata_a),
        .raddr_b (ram_raddr_b),
        .rdata_b (ram_rdata_b)
    );

    // Sequencer: schedule, per-byte swap with forwarding, output register.
    rc4_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .key_info    (key_info),
        .key_idx     (key_idx),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_raddr_a (ram_raddr_a),
        .ram_rdata_a (ram_rdata_a),
        .ram_raddr_b (ram_raddr_b),
        .ram_rdata_b (ram_rdata_b)
    );

endmodule

FILE: hdl/rc4_checker.sv
// Port-level checks on the RC4 stream cipher, bound to the top level.
`timescale 1ns / 1ps

module rc4_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input logic           out_valid,
    input logic           out_ready,
    input rc4_pkg::byte_t out_data
);

    logic       in_acc;
    logic       out_acc;
    logic [1:0] pending_reg;
    logic [1:0] pending_next;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_acc && !out_acc)
        begin
            pending_next = pending_reg + 2'd1;
        end
        else if (out_acc && !in_acc)
        begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("output word changed while stalled");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 2'd0)
        else $error("output word without an accepted input word");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> pending_reg <= 2'd1)
        else $error("input word taken with two words already in flight");

endmodule

bind rc4_stream_cipher rc4_checker u_rc4_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data_out)
);
